// ----- src/sba_pkg.sv -----
// Shared constants and control types for the sample block averager.
package sba_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int COUNT_BITS   = 16;
    localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
    localparam int TDATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DIV_STEPS    = SUM_BITS;
    localparam int STEP_BITS    = $clog2(DIV_STEPS);

    localparam logic [COUNT_BITS-1:0]  LENGTH_RESET = COUNT_BITS'(777);
    localparam logic [SAMPLE_BITS-1:0] AVG_MAX      = {SAMPLE_BITS{1'b1}};
    localparam logic [STEP_BITS-1:0]   LAST_STEP    = STEP_BITS'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } sba_state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_out;
    } sba_cmd_t;

    typedef struct packed {
        logic blk_end;
        logic div_last;
        logic out_busy;
    } sba_status_t;

endpackage

// ----- src/sample_block_averager_unit.sv -----
// Top level of the boxcar average decimator.
// An idle unit accepts a sample whenever s_tvalid is high. A sample that completes
// a block starts a one-bit-per-cycle restoring division of the 28-bit sum by the
// block length: s_tready then stays low through the division and the handoff state,
// longer only while the previous average still waits in the output register. The
// output register lets new samples enter while an average waits to be taken. A
// block length of zero acts as one; averages above 4095 saturate to 4095.
module sample_block_averager_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sba_pkg::COUNT_BITS-1:0]    cfg_wdata,   // block_length
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sba_pkg::TDATA_BITS-1:0]    s_tdata,     // [11:0] sample, rest zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sba_pkg::TDATA_BITS-1:0]    m_tdata      // [11:0] average, rest zero
);
    import sba_pkg::*;

    sba_cmd_t               cmd;
    sba_status_t            status;
    logic [SAMPLE_BITS-1:0] average;

    sba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .average   (average),
        .cmd       (cmd),
        .status    (status)
    );

    assign m_tdata = TDATA_BITS'(average);

endmodule

// ----- src/sba_ctrl.sv -----
// Controller state machine: sample intake, serial division, result handoff.
module sba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sba_pkg::sba_status_t status,
    output sba_pkg::sba_cmd_t    cmd
);
    import sba_pkg::*;

    sba_state_t state_reg;
    sba_state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.blk_end)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold the quotient until the output register frees up
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/sba_dp.sv -----
// Datapath: length register, accumulator, restoring divider, output register.
module sba_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sba_pkg::COUNT_BITS-1:0]      cfg_wdata,
    input  logic [sba_pkg::SAMPLE_BITS-1:0]     sample,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [sba_pkg::SAMPLE_BITS-1:0]     average,
    input  sba_pkg::sba_cmd_t                   cmd,
    output sba_pkg::sba_status_t                status
);
    import sba_pkg::*;

    logic [COUNT_BITS-1:0]  len_reg;
    logic [SUM_BITS-1:0]    sum_reg,     sum_next;
    logic [COUNT_BITS-1:0]  count_reg,   count_next;
    logic [SUM_BITS-1:0]    dvd_reg,     dvd_next;
    logic [COUNT_BITS-1:0]  rem_reg,     rem_next;
    logic [COUNT_BITS-1:0]  divisor_reg, divisor_next;
    logic [STEP_BITS-1:0]   step_reg,    step_next;
    logic                   valid_reg,   valid_next;
    logic [SAMPLE_BITS-1:0] avg_reg,     avg_next;

    logic [COUNT_BITS-1:0]  len_eff;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [SUM_BITS-1:0]    sum_inc;
    logic [COUNT_BITS:0]    shifted;
    logic [COUNT_BITS:0]    diff;
    logic                   q_bit;
    logic                   blk_end;
    logic                   q_over;

    always_comb
    begin
        // a zero length behaves as one
        len_eff   = (len_reg == '0) ? COUNT_BITS'(1) : len_reg;
        count_inc = count_reg + COUNT_BITS'(1);
        sum_inc   = sum_reg + SUM_BITS'(sample);
        blk_end   = (count_inc >= len_eff);

        shifted = {rem_reg, dvd_reg[SUM_BITS-1]};
        diff    = shifted - {1'b0, divisor_reg};
        q_bit   = (shifted >= {1'b0, divisor_reg});
        q_over  = |dvd_reg[SUM_BITS-1:SAMPLE_BITS];

        sum_next     = sum_reg;
        count_next   = count_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        step_next    = step_reg;
        valid_next   = valid_reg && !m_tready;
        avg_next     = avg_reg;

        if (cmd.accept)
        begin
            if (blk_end)
            begin
                sum_next     = '0;
                count_next   = '0;
                dvd_next     = sum_inc;
                rem_next     = '0;
                divisor_next = len_eff;
                step_next    = '0;
            end
            else
            begin
                sum_next   = sum_inc;
                count_next = count_inc;
            end
        end

        if (cmd.div_step)
        begin
            rem_next  = q_bit ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            dvd_next  = {dvd_reg[SUM_BITS-2:0], q_bit};
            step_next = step_reg + STEP_BITS'(1);
        end

        if (cmd.load_out)
        begin
            valid_next = 1'b1;
            avg_next   = q_over ? AVG_MAX : dvd_reg[SAMPLE_BITS-1:0];
        end

        status.blk_end  = blk_end;
        status.div_last = (step_reg == LAST_STEP);
        status.out_busy = valid_reg && !m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LENGTH_RESET;
            sum_reg   <= '0;
            count_reg <= '0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
            sum_reg   <= sum_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        avg_reg     <= avg_next;
    end

    assign m_tvalid = valid_reg;
    assign average  = avg_reg;

endmodule

// ----- src/sba_checker.sv -----
// Port-level checker for the averager, bound to the top level.
module sba_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [sba_pkg::TDATA_BITS-1:0]    m_tdata
);
    import sba_pkg::*;

    // a stalled result transaction keeps valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // a stalled result keeps its data
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // a fresh result only follows the division, during which intake is closed
    a_rise_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a division phase");

    // padding above the average stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[TDATA_BITS-1:SAMPLE_BITS] == '0))
        else $error("m_tdata padding not zero");

endmodule

bind sample_block_averager_unit sba_checker u_sba_checker (.*);
